// ===== rtl/chrt_pkg.sv =====
// shared constants, codes and entry type for the ring point table
// no dependencies
package chrt_pkg;

    localparam int RING_POINTS = 1024;
    localparam int OWNER_BITS  = 8;

    localparam int ADDR_W  = $clog2(RING_POINTS);
    localparam int CNT_W   = $clog2(RING_POINTS + 1);
    localparam int HASH_W  = 32;
    localparam int FUNC_W  = 2;
    localparam int NODE_W  = 8;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 11;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;

    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [HASH_W-1:0]     hash;
        logic [OWNER_BITS-1:0] owner;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/consistent_hash_ring_table.sv =====
// ring point table top level: sequencer around one point memory
// depends on chrt_pkg and chrt_ram
//
// Keeps up to RING_POINTS (hash, owner) points sorted by hash in one memory with a
// registered read. One word is worked on at a time; the next input word is taken
// while a finished result still waits on the m_ side. Every probe of the binary
// search is a memory read state, then a compare state. Insert runs the same search,
// then moves each point above the insert position up by one, a read state and a
// write state per point. Remove walks the whole table the same way, compacting in
// place. Full insert, empty lookup and unused codes skip the search and go straight
// to the output state. The memory needs no clearing after reset.
module consistent_hash_ring_table
    import chrt_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [FUNC_W-1:0]   s_func,
    input  logic [HASH_W-1:0]   s_point_hash,
    input  logic [NODE_W-1:0]   s_node_id,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STAT_W-1:0]   m_status,
    output logic [NODE_W-1:0]   m_owner_id,
    output logic [COUNT_W-1:0]  m_point_count
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_LK_RD,
        ST_LK_DATA,
        ST_SH_RD,
        ST_SH_WR,
        ST_RM_RD,
        ST_RM_WR,
        ST_OUT
    } state_t;

    state_t                 state_reg;
    logic [FUNC_W-1:0]      func_reg;
    logic [HASH_W-1:0]      hash_reg;
    logic [OWNER_BITS-1:0]  owner_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       lo_reg;
    logic [CNT_W-1:0]       hi_reg;
    logic [CNT_W-1:0]       idx_reg;
    logic [CNT_W-1:0]       wr_reg;
    logic [STAT_W-1:0]      res_status_reg;
    logic [NODE_W-1:0]      res_owner_reg;
    logic                   m_valid_reg;
    logic [STAT_W-1:0]      m_status_reg;
    logic [NODE_W-1:0]      m_owner_reg;
    logic [COUNT_W-1:0]     m_count_reg;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    entry_t                 ram_wdata;
    logic                   ram_re;
    logic [ADDR_W-1:0]      ram_raddr;
    entry_t                 ram_rdata;
    logic [CNT_W-1:0]       mid;
    logic                   go_right;
    logic [CNT_W-1:0]       idx_dec;

    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign idx_dec = idx_reg - CNT_W'(1);

    // lookup wants the first hash >= key, insert the first hash > key
    always_comb begin
        if (func_reg == FUNC_LOOKUP) begin
            go_right = ram_rdata.hash < hash_reg;
        end else begin
            go_right = ram_rdata.hash <= hash_reg;
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg[ADDR_W-1:0];
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = mid[ADDR_W-1:0];
        case (state_reg)
            ST_SRCH_RD: begin
                ram_re = 1'b1;
            end
            ST_LK_RD: begin
                ram_re    = 1'b1;
                ram_raddr = (lo_reg >= count_reg) ? '0 : lo_reg[ADDR_W-1:0];
            end
            ST_SH_RD: begin
                if (idx_reg == lo_reg) begin
                    ram_we          = 1'b1;
                    ram_wdata.hash  = hash_reg;
                    ram_wdata.owner = owner_reg;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_dec[ADDR_W-1:0];
                end
            end
            ST_SH_WR: begin
                ram_we = 1'b1;
            end
            ST_RM_RD: begin
                ram_re    = idx_reg != count_reg;
                ram_raddr = idx_reg[ADDR_W-1:0];
            end
            ST_RM_WR: begin
                ram_we    = ram_rdata.owner != owner_reg;
                ram_waddr = wr_reg[ADDR_W-1:0];
            end
            default: begin
            end
        endcase
    end

    chrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RING_POINTS)
    ) u_points (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // in ST_OUT the output word is reloaded below instead
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        func_reg       <= s_func;
                        hash_reg       <= s_point_hash;
                        owner_reg      <= OWNER_BITS'(s_node_id);
                        lo_reg         <= '0;
                        hi_reg         <= count_reg;
                        idx_reg        <= '0;
                        wr_reg         <= '0;
                        res_status_reg <= STATUS_OK;
                        res_owner_reg  <= '0;
                        case (s_func)
                            FUNC_INSERT: begin
                                if (count_reg >= CNT_W'(RING_POINTS)) begin
                                    res_status_reg <= STATUS_FULL;
                                    state_reg      <= ST_OUT;
                                end else begin
                                    state_reg <= ST_SRCH_RD;
                                end
                            end
                            FUNC_REMOVE: begin
                                state_reg <= ST_RM_RD;
                            end
                            FUNC_LOOKUP: begin
                                if (count_reg == '0) begin
                                    res_status_reg <= STATUS_EMPTY;
                                    state_reg      <= ST_OUT;
                                end else begin
                                    state_reg <= ST_SRCH_RD;
                                end
                            end
                            default: begin
                                state_reg <= ST_OUT;
                            end
                        endcase
                    end
                end
                ST_SRCH_RD: begin
                    if (lo_reg >= hi_reg) begin
                        if (func_reg == FUNC_LOOKUP) begin
                            state_reg <= ST_LK_RD;
                        end else begin
                            idx_reg   <= count_reg;
                            state_reg <= ST_SH_RD;
                        end
                    end else begin
                        state_reg <= ST_SRCH_CMP;
                    end
                end
                ST_SRCH_CMP: begin
                    if (go_right) begin
                        lo_reg <= mid + CNT_W'(1);
                    end else begin
                        hi_reg <= mid;
                    end
                    state_reg <= ST_SRCH_RD;
                end
                ST_LK_RD: begin
                    state_reg <= ST_LK_DATA;
                end
                ST_LK_DATA: begin
                    res_owner_reg <= NODE_W'(ram_rdata.owner);
                    state_reg     <= ST_OUT;
                end
                ST_SH_RD: begin
                    // lo_reg holds the insert position here
                    if (idx_reg == lo_reg) begin
                        count_reg <= count_reg + CNT_W'(1);
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_SH_WR;
                    end
                end
                ST_SH_WR: begin
                    idx_reg   <= idx_dec;
                    state_reg <= ST_SH_RD;
                end
                ST_RM_RD: begin
                    if (idx_reg == count_reg) begin
                        count_reg <= wr_reg;
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_RM_WR;
                    end
                end
                ST_RM_WR: begin
                    if (ram_rdata.owner != owner_reg) begin
                        wr_reg <= wr_reg + CNT_W'(1);
                    end
                    idx_reg   <= idx_reg + CNT_W'(1);
                    state_reg <= ST_RM_RD;
                end
                ST_OUT: begin
                    // hand over once the output word is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_owner_reg  <= res_owner_reg;
                        m_count_reg  <= COUNT_W'(count_reg);
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready       = state_reg == ST_IDLE;
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_owner_id    = m_owner_reg;
    assign m_point_count = m_count_reg;

endmodule

// ===== rtl/chrt_ram.sv =====
// generic simple dual port ram, one write port and one registered read port
// no dependencies
module chrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== tb/chrt_ring_checker.sv =====
`timescale 1ns / 1ps
// checker for the ring point table: watches both channels, predicts each result word
// from its own sorted copy of the ring and compares; depends on chrt_pkg
module chrt_ring_checker
    import chrt_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [FUNC_W-1:0]   s_func,
    input  logic [HASH_W-1:0]   s_point_hash,
    input  logic [NODE_W-1:0]   s_node_id,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [STAT_W-1:0]   m_status,
    input  logic [NODE_W-1:0]   m_owner_id,
    input  logic [COUNT_W-1:0]  m_point_count,
    output int                  fails,
    output int                  pending,
    output int                  checked,
    output int                  full_hits,
    output int                  empty_hits,
    output int                  wrap_hits,
    output int                  peak_points
);

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [NODE_W-1:0]  owner;
        logic [COUNT_W-1:0] count;
    } answer_t;

    logic [HASH_W-1:0]     ring_hash  [RING_POINTS];
    logic [OWNER_BITS-1:0] ring_owner [RING_POINTS];
    int                    ring_size = 0;
    answer_t               answers_due[$];

    initial begin
        fails       = 0;
        pending     = 0;
        checked     = 0;
        full_hits   = 0;
        empty_hits  = 0;
        wrap_hits   = 0;
        peak_points = 0;
    end

    // new point goes above every point with an equal hash
    function automatic void ring_insert(input logic [HASH_W-1:0] h,
                                        input logic [OWNER_BITS-1:0] o);
        int slot;
        slot = ring_size;
        while (slot > 0 && ring_hash[slot-1] > h) begin
            ring_hash[slot]  = ring_hash[slot-1];
            ring_owner[slot] = ring_owner[slot-1];
            slot--;
        end
        ring_hash[slot]  = h;
        ring_owner[slot] = o;
        ring_size++;
        if (ring_size > peak_points)
            peak_points = ring_size;
    endfunction

    function automatic void ring_drop_owner(input logic [OWNER_BITS-1:0] o);
        int keep;
        int i;
        keep = 0;
        for (i = 0; i < ring_size; i++) begin
            if (ring_owner[i] != o) begin
                ring_hash[keep]  = ring_hash[i];
                ring_owner[keep] = ring_owner[i];
                keep++;
            end
        end
        ring_size = keep;
    endfunction

    // first point at or above h, else wrap to the bottom of the ring
    function automatic int ring_find(input logic [HASH_W-1:0] h);
        int i;
        for (i = 0; i < ring_size; i++)
            if (ring_hash[i] >= h)
                return i;
        wrap_hits++;
        return 0;
    endfunction

    function automatic answer_t ring_answer(input logic [FUNC_W-1:0] f,
                                            input logic [HASH_W-1:0] h,
                                            input logic [NODE_W-1:0] n);
        answer_t               a;
        logic [OWNER_BITS-1:0] o;
        a.status = STATUS_OK;
        a.owner  = '0;
        o        = OWNER_BITS'(n);
        case (f)
            FUNC_INSERT: begin
                if (ring_size >= RING_POINTS) begin
                    a.status = STATUS_FULL;
                    full_hits++;
                end else begin
                    ring_insert(h, o);
                end
            end
            FUNC_REMOVE: ring_drop_owner(o);
            FUNC_LOOKUP: begin
                if (ring_size == 0) begin
                    a.status = STATUS_EMPTY;
                    empty_hits++;
                end else begin
                    a.owner = NODE_W'(ring_owner[ring_find(h)]);
                end
            end
            default: ;
        endcase
        a.count = COUNT_W'(ring_size);
        return a;
    endfunction

    always @(posedge aclk) begin : watch
        answer_t want;
        answer_t got;
        if (aresetn) begin
            // a result word can never belong to the word taken at this same edge
            if (m_valid && m_ready) begin
                got.status = m_status;
                got.owner  = m_owner_id;
                got.count  = m_point_count;
                if (answers_due.size() == 0) begin
                    fails++;
                    $display("t=%0t: result word with nothing expected, status %0d owner %0d count %0d",
                             $time, got.status, got.owner, got.count);
                end else begin
                    want = answers_due.pop_front();
                    checked++;
                    if (got.status !== want.status) begin
                        fails++;
                        $display("t=%0t: status expected %0d, got %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.owner !== want.owner) begin
                        fails++;
                        $display("t=%0t: owner_id expected %0d, got %0d",
                                 $time, want.owner, got.owner);
                    end
                    if (got.count !== want.count) begin
                        fails++;
                        $display("t=%0t: point_count expected %0d, got %0d",
                                 $time, want.count, got.count);
                    end
                end
            end
            if (s_valid && s_ready)
                answers_due.push_back(ring_answer(s_func, s_point_hash, s_node_id));
            pending = answers_due.size();
        end
    end

endmodule

// ===== tb/tb_consistent_hash_ring_table.sv =====
`timescale 1ns / 1ps
// top of the ring point table testbench: clock, reset, request stimulus and verdict
// depends on chrt_pkg, consistent_hash_ring_table and chrt_ring_checker
module tb_consistent_hash_ring_table;
    import chrt_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;
    localparam int OWNER_POOL = 12;
    localparam int FILL_POOL  = 8;
    localparam int HOLD_CYCLES = 400;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [FUNC_W-1:0]   s_func;
    logic [HASH_W-1:0]   s_point_hash;
    logic [NODE_W-1:0]   s_node_id;
    logic                m_valid;
    logic                m_ready;
    logic [STAT_W-1:0]   m_status;
    logic [NODE_W-1:0]   m_owner_id;
    logic [COUNT_W-1:0]  m_point_count;

    int fails, pending, checked, full_hits, empty_hits, wrap_hits, peak_points;

    bit tx_idle_on  = 1'b1;
    bit rx_idle_on  = 1'b1;
    bit rx_hold_req = 1'b0;

    logic [NODE_W-1:0] owner_pool [OWNER_POOL];
    logic [NODE_W-1:0] fill_pool  [FILL_POOL];
    logic [HASH_W-1:0] known_hashes[$];

    consistent_hash_ring_table u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_point_hash  (s_point_hash),
        .s_node_id     (s_node_id),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_owner_id    (m_owner_id),
        .m_point_count (m_point_count)
    );

    chrt_ring_checker u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_point_hash  (s_point_hash),
        .s_node_id     (s_node_id),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_owner_id    (m_owner_id),
        .m_point_count (m_point_count),
        .fails         (fails),
        .pending       (pending),
        .checked       (checked),
        .full_hits     (full_hits),
        .empty_hits    (empty_hits),
        .wrap_hits     (wrap_hits),
        .peak_points   (peak_points)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        #50_000_000;
        $display("timeout with %0d result words still due", pending);
        $display("status: fail");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin : rx_side
        int held;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(negedge aclk);
            end else begin
                m_ready <= !(rx_idle_on && $urandom_range(99) < 23);
            end
        end
    end

    // entered and left at a falling edge
    task automatic send_word(input logic [FUNC_W-1:0] f, input logic [HASH_W-1:0] h,
                             input logic [NODE_W-1:0] n);
        if (tx_idle_on && $urandom_range(99) < 23) begin
            s_valid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(99) < 23)
                @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_func       <= f;
        s_point_hash <= h;
        s_node_id    <= n;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic mixed_traffic(input int words);
        int                k;
        int                r;
        logic [FUNC_W-1:0] f;
        logic [HASH_W-1:0] h;
        logic [NODE_W-1:0] n;
        for (k = 0; k < words; k++) begin
            r = $urandom_range(99);
            f = (r < 35) ? FUNC_INSERT : (r < 45) ? FUNC_REMOVE :
                (r < 95) ? FUNC_LOOKUP : FUNC_NOP;
            n = ($urandom_range(99) < 80) ? owner_pool[$urandom_range(OWNER_POOL-1)]
                                          : NODE_W'($urandom);
            r = $urandom_range(99);
            if (r < 10) begin
                h = $urandom_range(1) ? '1 : '0;
            end else if (r < 45 && known_hashes.size() > 0) begin
                // equal hashes, and lookups just either side of a point
                h = known_hashes[$urandom_range(known_hashes.size()-1)];
                if (f == FUNC_LOOKUP && r < 25)
                    h = h + HASH_W'($urandom_range(2)) - 1;
            end else begin
                h = $urandom;
            end
            if (f == FUNC_INSERT) begin
                known_hashes.push_back(h);
                if (known_hashes.size() > 64)
                    known_hashes.delete(0);
            end
            send_word(f, h, n);
        end
    endtask

    initial begin : stimulus
        int k;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_func       = FUNC_INSERT;
        s_point_hash = '0;
        s_node_id    = '0;
        foreach (owner_pool[k])
            owner_pool[k] = NODE_W'($urandom);
        foreach (fill_pool[k])
            fill_pool[k] = NODE_W'($urandom);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty ring corners
        send_word(FUNC_LOOKUP, 32'h0000_0000, 8'h00);
        send_word(FUNC_REMOVE, 32'h0000_0000, 8'h05);
        send_word(FUNC_NOP,    32'hFFFF_FFFF, 8'hFF);
        // extremes and equal hashes
        send_word(FUNC_INSERT, 32'h8000_0000, 8'h01);
        send_word(FUNC_INSERT, 32'h0000_0000, 8'h00);
        send_word(FUNC_INSERT, 32'hFFFF_FFFF, 8'hFF);
        send_word(FUNC_INSERT, 32'h8000_0000, 8'h02);
        send_word(FUNC_INSERT, 32'h8000_0000, 8'h03);
        send_word(FUNC_LOOKUP, 32'h8000_0000, 8'h00);
        send_word(FUNC_LOOKUP, 32'h7FFF_FFFF, 8'h00);
        send_word(FUNC_LOOKUP, 32'h8000_0001, 8'h00);
        send_word(FUNC_LOOKUP, 32'hFFFF_FFFF, 8'h00);
        send_word(FUNC_LOOKUP, 32'h0000_0000, 8'h00);
        // top point gone, so the highest key wraps to the bottom
        send_word(FUNC_REMOVE, 32'h0000_0000, 8'hFF);
        send_word(FUNC_LOOKUP, 32'hFFFF_FFFF, 8'h00);
        send_word(FUNC_REMOVE, 32'h0000_0000, 8'h02);
        send_word(FUNC_LOOKUP, 32'h8000_0000, 8'h00);
        send_word(FUNC_REMOVE, 32'h0000_0000, 8'h77);
        send_word(FUNC_NOP,    32'h5555_5555, 8'hAA);
        send_word(FUNC_INSERT, 32'h5555_5555, 8'hAA);
        send_word(FUNC_INSERT, 32'hAAAA_AAAA, 8'h55);
        send_word(FUNC_LOOKUP, 32'h5555_5556, 8'h00);
        send_word(FUNC_REMOVE, 32'h0000_0000, 8'h00);
        send_word(FUNC_LOOKUP, 32'h0000_0000, 8'h00);

        mixed_traffic(150);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        mixed_traffic(120);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        mixed_traffic(80);

        // fill to capacity with rising hashes so few points move; the long
        // result hold-off at the start backs the block up
        rx_hold_req = 1'b1;
        for (k = 0; k < RING_POINTS + 16; k++)
            send_word(FUNC_INSERT,
                      32'hF000_0000 + HASH_W'(k) * 32'h0003_0000 +
                      HASH_W'($urandom_range(32'h0002_FFFF)),
                      fill_pool[$urandom_range(FILL_POOL-1)]);
        for (k = 0; k < 24; k++)
            send_word(FUNC_LOOKUP, (k < 2) ? {HASH_W{k[0]}} : HASH_W'($urandom), 8'h00);
        send_word(FUNC_NOP, $urandom, NODE_W'($urandom));
        foreach (fill_pool[k]) begin
            send_word(FUNC_REMOVE, $urandom, fill_pool[k]);
            send_word(FUNC_LOOKUP, $urandom, 8'h00);
            send_word(FUNC_INSERT, $urandom, fill_pool[k]);
        end
        foreach (owner_pool[k])
            send_word(FUNC_REMOVE, $urandom, owner_pool[k]);
        mixed_traffic(40);

        s_valid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (2 * RING_POINTS + 64) @(posedge aclk);

        $display("checked %0d result words, ring grew to %0d points", checked, peak_points);
        $display("%0d inserts refused as full, %0d lookups on an empty ring, %0d wrapped",
                 full_hits, empty_hits, wrap_hits);
        if (fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
